// ===== rtl/assert_macros.svh =====
// assertion macros shared by the straight drive controller rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define SDC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// consequent checked in the cycle after the antecedent
`define SDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);

`endif

// ===== rtl/sdc_pkg.sv =====
// shared constants, codes and angle helpers for the straight drive controller
package sdc_pkg;

  localparam logic [1:0] ACT_START  = 2'd0;
  localparam logic [1:0] ACT_UPDATE = 2'd1;
  localparam logic [1:0] ACT_CANCEL = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [1:0] RUN_IDLE = 2'd0;
  localparam logic [1:0] RUN_BUSY = 2'd1;
  localparam logic [1:0] RUN_OK   = 2'd2;
  localparam logic [1:0] RUN_FAIL = 2'd3;

  localparam logic [2:0] REG_TARGET    = 3'd0;
  localparam logic [2:0] REG_POS_TOL   = 3'd1;
  localparam logic [2:0] REG_HEAD_TOL  = 3'd2;
  localparam logic [2:0] REG_DIST_GAIN = 3'd3;
  localparam logic [2:0] REG_HEAD_GAIN = 3'd4;
  localparam logic [2:0] REG_SLOW_ZONE = 3'd5;
  localparam logic [2:0] REG_TIMEOUT   = 3'd6;
  localparam logic [2:0] REG_MAX_CORR  = 3'd7;

  localparam logic signed [17:0] ANG_PI      = 18'sd25736;
  localparam logic signed [17:0] ANG_TWO_PI  = 18'sd51472;
  localparam logic signed [17:0] ANG_HALF_PI = 18'sd12868;

  localparam int CORDIC_STEPS = 16;
  localparam logic signed [22:0] CORDIC_GAIN_Q20 = 23'sd636751;

  localparam logic [16:0] ATAN_Q16 [CORDIC_STEPS] = '{
    17'd51472, 17'd30386, 17'd16055, 17'd8150, 17'd4091, 17'd2047, 17'd1024, 17'd512,
    17'd256, 17'd128, 17'd64, 17'd32, 17'd16, 17'd8, 17'd4, 17'd2};

  // single wrap into (-pi, pi]
  function automatic logic signed [17:0] wrap_angle(input logic signed [17:0] a);
    logic signed [17:0] r;
    r = a;
    if (a <= -ANG_PI) r = a + ANG_TWO_PI;
    else if (a > ANG_PI) r = a - ANG_TWO_PI;
    return r;
  endfunction

endpackage

// ===== rtl/sdc_mul.sv =====
// registered signed multiplier shared by all products of the controller
module sdc_mul
  import sdc_pkg::*;
(
  input  logic               clk,
  input  logic signed [24:0] a,
  input  logic signed [20:0] b,
  output logic signed [45:0] p
);

  always_ff @(posedge clk) begin
    p <= 46'(a * b);
  end

endmodule

// ===== rtl/sdc_cordic.sv =====
// iterative cordic giving the q1.14 cosine and sine of a heading
module sdc_cordic
  import sdc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] angle,
  output logic               done,
  output logic signed [15:0] cosine,
  output logic signed [15:0] sine
);

  logic               busy;
  logic               post;
  logic [3:0]         step;
  logic signed [22:0] x, y;
  logic signed [19:0] z;
  logic               neg;

  logic signed [17:0] a_wrap, a_fold;
  logic               neg_start;
  logic signed [22:0] xs, ys;
  logic signed [19:0] atan_z;
  logic signed [22:0] xr, yr;
  logic signed [15:0] xc, yc;

  always_comb begin
    a_wrap = wrap_angle(18'(angle));
    a_fold = a_wrap;
    neg_start = 1'b0;
    if (a_wrap > ANG_HALF_PI) begin
      a_fold = a_wrap - ANG_PI;
      neg_start = 1'b1;
    end else if (a_wrap < -ANG_HALF_PI) begin
      a_fold = a_wrap + ANG_PI;
      neg_start = 1'b1;
    end
    xs = x >>> step;
    ys = y >>> step;
    atan_z = 20'(ATAN_Q16[step]);
    // round to q1.14 and limit to plus or minus one
    xr = (x + 23'sd32) >>> 6;
    yr = (y + 23'sd32) >>> 6;
    xc = (xr > 23'sd16384) ? 16'sd16384 : ((xr < -23'sd16384) ? -16'sd16384 : xr[15:0]);
    yc = (yr > 23'sd16384) ? 16'sd16384 : ((yr < -23'sd16384) ? -16'sd16384 : yr[15:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      post <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 4'd1;
        if (step == 4'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          post <= 1'b1;
        end
      end else if (post) begin
        post <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x   <= CORDIC_GAIN_Q20;
      y   <= '0;
      z   <= {a_fold[16:0], 3'b000};
      neg <= neg_start;
    end else if (busy) begin
      if (!z[19]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - atan_z;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + atan_z;
      end
    end else if (post) begin
      cosine <= neg ? -xc : xc;
      sine   <= neg ? -yc : yc;
    end
  end

endmodule

// ===== rtl/sdc_div.sv =====
// bit serial restoring divider for the progress fraction
module sdc_div
  import sdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [23:0] num,
  input  logic [23:0] den,
  output logic        done,
  output logic [15:0] quot
);

  logic        busy;
  logic [3:0]  cnt;
  logic [23:0] rem;
  logic [23:0] den_r;
  logic [24:0] trial;
  logic        fits;

  always_comb begin
    trial = {rem, 1'b0};
    fits  = trial >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // numerator is below the divisor, so sixteen quotient bits suffice
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num;
      den_r <= den;
      quot  <= '0;
    end else if (busy) begin
      rem  <= fits ? 24'(trial - {1'b0, den_r}) : trial[23:0];
      quot <= {quot[14:0], fits};
    end
  end

endmodule

// ===== rtl/straight_drive_controller.sv =====
// straight drive controller top level: sequencer, registers and result shaping
//
// Input channel (in_valid/in_stall) takes one transaction per action: start latches
// the pose and target and runs a 16 step cordic (input stalled until the cordic is
// done); cancel fails the run; update gives one result on the output channel. An
// update while not running, or one that times out, answers in the next cycle; a
// running update steps through S_MX, S_MY, S_AL, S_MB, S_MC and S_FN, with the 16
// step bit serial divider (S_DV) after S_AL when the progress needs a division, and
// the shared registered multiplier serves the products.
// Output channel (out_valid/out_stall) holds its result until taken; while a
// result waits, in_stall stays high. Unused action codes are dropped.
// Config writes (cfg_write, cfg_index, cfg_data) are registered and must only
// happen while the block is idle.
// Reset (rst, synchronous) restores the register defaults, clears the run state
// and drops any pending result.
module straight_drive_controller
  import sdc_pkg::*;
#(
  parameter int MAX_PWM  = 255,
  parameter int MIN_PWM  = 40,
  parameter int DEADBAND = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         action,
  input  logic signed [19:0] pose_x,
  input  logic signed [19:0] pose_y,
  input  logic signed [15:0] pose_heading,
  input  logic signed [20:0] time_step,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [8:0]  left_drive,
  output logic signed [8:0]  right_drive,
  output logic               finished,
  output logic               succeeded,
  output logic [16:0]        progress
);

  `include "assert_macros.svh"

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_CORD = 9'b000000010,
    S_MX   = 9'b000000100,
    S_MY   = 9'b000001000,
    S_AL   = 9'b000010000,
    S_DV   = 9'b000100000,
    S_MB   = 9'b001000000,
    S_MC   = 9'b010000000,
    S_FN   = 9'b100000000
  } state_t;

  localparam logic signed [17:0] MAXS  = 18'(MAX_PWM);
  localparam logic signed [17:0] DBS   = 18'(DEADBAND);
  localparam logic [15:0]        MAXU  = 16'(MAX_PWM);
  localparam logic [15:0]        MINU  = 16'(MIN_PWM);
  localparam logic [16:0]        FULL  = 17'd65536;

  state_t state;

  // configuration
  logic signed [19:0] target_distance;
  logic [15:0] position_tolerance;
  logic [14:0] heading_tolerance;
  logic [19:0] distance_gain;
  logic [19:0] heading_gain;
  logic [18:0] slow_zone;
  logic [31:0] timeout_us;
  logic [14:0] max_correction;

  // run state
  logic [1:0]         run_status;
  logic signed [19:0] start_x, start_y, latched_target;
  logic signed [15:0] start_heading, start_cosine, start_sine;
  logic [31:0]        elapsed_us;
  logic signed [19:0] cur_x, cur_y;
  logic signed [15:0] cur_heading;
  logic signed [45:0] acc;
  logic signed [23:0] along;
  logic signed [17:0] base;

  logic in_acc, out_acc;
  logic cor_start, cor_done;
  logic signed [15:0] cor_cos, cor_sin;
  logic div_start, div_done;
  logic [15:0] div_quot;
  logic [23:0] abs_al, abs_tg;

  logic signed [24:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [45:0] prod;

  logic [32:0]        elapsed_sum;
  logic [31:0]        elapsed_next;
  logic               timed_out;
  logic signed [46:0] sum;
  logic signed [23:0] along_next;
  logic signed [24:0] remaining;
  logic [24:0]        rem_abs;
  logic signed [17:0] h_err;
  logic [17:0]        herr_abs;
  logic [45:0]        prod_mag;
  logic [45:0]        bsh, csh;
  logic [15:0]        bmag;
  logic [14:0]        cmag;
  logic signed [17:0] base_c, corr, base_use;
  logic               in_tol, settled;
  logic signed [17:0] left_c, right_c;

  function automatic logic signed [17:0] shape(input logic signed [17:0] v);
    logic signed [17:0] c;
    c = (v > MAXS) ? MAXS : ((v < -MAXS) ? -MAXS : v);
    if (c > -DBS && c < DBS) c = '0;
    return c;
  endfunction

  assign in_stall  = (state != S_IDLE) || out_valid;
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign cor_start = in_acc && (action == ACT_START);

  sdc_cordic u_cordic (
    .clk    (clk),
    .rst    (rst),
    .start  (cor_start),
    .angle  (pose_heading),
    .done   (cor_done),
    .cosine (cor_cos),
    .sine   (cor_sin)
  );

  sdc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (abs_al),
    .den   (abs_tg),
    .done  (div_done),
    .quot  (div_quot)
  );

  sdc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  always_comb begin
    elapsed_sum = {1'b0, elapsed_us} +
                  ((time_step > 21'sd0) ? {13'b0, time_step[19:0]} : 33'd0);
    elapsed_next = elapsed_sum[32] ? 32'hFFFF_FFFF : elapsed_sum[31:0];
    timed_out = (timeout_us != 32'd0) && (elapsed_next > timeout_us);

    sum = 47'(acc) + 47'(prod);
    along_next = sum[37:14];
    abs_al = along_next[23] ? 24'(-along_next) : 24'(along_next);
    abs_tg = latched_target[19] ? 24'(-25'(latched_target)) : 24'(latched_target);
    div_start = (state == S_AL) && (latched_target != 20'sd0) && (abs_al < abs_tg);

    remaining = 25'(latched_target) - 25'(along);
    rem_abs   = remaining[24] ? 25'(-remaining) : 25'(remaining);
    h_err     = wrap_angle(18'(start_heading) - 18'(cur_heading));
    herr_abs  = h_err[17] ? 18'(-h_err) : 18'(h_err);

    mul_a = 25'(cur_x) - 25'(start_x);
    mul_b = 21'(start_cosine);
    case (state)
      S_MY: begin
        mul_a = 25'(cur_y) - 25'(start_y);
        mul_b = 21'(start_sine);
      end
      S_MB: begin
        mul_a = remaining;
        mul_b = {1'b0, distance_gain};
      end
      S_MC: begin
        mul_a = 25'(h_err);
        mul_b = {1'b0, heading_gain};
      end
      default: ;
    endcase

    // truncation toward zero works on the magnitude
    prod_mag = prod[45] ? 46'(-prod) : 46'(prod);
    bsh  = prod_mag >> 18;
    bmag = (bsh > 46'(MAX_PWM)) ? MAXU : bsh[15:0];
    if (rem_abs > {6'b0, slow_zone} && bmag != 16'd0 && bmag < MINU) bmag = MINU;
    base_c = prod[45] ? -18'(bmag) : 18'(bmag);
    csh  = prod_mag >> 21;
    cmag = (csh > {31'b0, max_correction}) ? max_correction : csh[14:0];
    corr = prod[45] ? -18'(cmag) : 18'(cmag);

    in_tol   = rem_abs <= {9'b0, position_tolerance};
    settled  = herr_abs <= {3'b0, heading_tolerance};
    base_use = in_tol ? 18'sd0 : base;
    left_c   = shape(base_use - corr);
    right_c  = shape(base_use + corr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_distance    <= '0;
      position_tolerance <= 16'd20;
      heading_tolerance  <= 15'd400;
      distance_gain      <= '0;
      heading_gain       <= '0;
      slow_zone          <= '0;
      timeout_us         <= '0;
      max_correction     <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TARGET:    target_distance    <= cfg_data[19:0];
        REG_POS_TOL:   position_tolerance <= cfg_data[15:0];
        REG_HEAD_TOL:  heading_tolerance  <= cfg_data[14:0];
        REG_DIST_GAIN: distance_gain      <= cfg_data[19:0];
        REG_HEAD_GAIN: heading_gain       <= cfg_data[19:0];
        REG_SLOW_ZONE: slow_zone          <= cfg_data[18:0];
        REG_TIMEOUT:   timeout_us         <= cfg_data[31:0];
        REG_MAX_CORR:  max_correction     <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      run_status     <= RUN_IDLE;
      out_valid      <= 1'b0;
      start_x        <= '0;
      start_y        <= '0;
      start_heading  <= '0;
      start_cosine   <= '0;
      start_sine     <= '0;
      latched_target <= '0;
      elapsed_us     <= '0;
      progress       <= '0;
    end else begin
      if (out_acc) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            case (action)
              ACT_START: begin
                start_x        <= pose_x;
                start_y        <= pose_y;
                start_heading  <= pose_heading;
                latched_target <= target_distance;
                elapsed_us     <= '0;
                progress       <= '0;
                run_status     <= RUN_BUSY;
                state          <= S_CORD;
              end
              ACT_CANCEL: run_status <= RUN_FAIL;
              ACT_UPDATE: begin
                cur_x       <= pose_x;
                cur_y       <= pose_y;
                cur_heading <= pose_heading;
                if (run_status == RUN_BUSY) begin
                  elapsed_us <= elapsed_next;
                  if (timed_out) begin
                    run_status  <= RUN_FAIL;
                    out_valid   <= 1'b1;
                    finished    <= 1'b1;
                    succeeded   <= 1'b0;
                    left_drive  <= '0;
                    right_drive <= '0;
                  end else begin
                    state <= S_MX;
                  end
                end else begin
                  out_valid   <= 1'b1;
                  finished    <= 1'b1;
                  succeeded   <= (run_status == RUN_OK);
                  left_drive  <= '0;
                  right_drive <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_CORD: begin
          if (cor_done) begin
            start_cosine <= cor_cos;
            start_sine   <= cor_sin;
            state        <= S_IDLE;
          end
        end
        S_MX: state <= S_MY;
        S_MY: begin
          acc   <= prod;
          state <= S_AL;
        end
        S_AL: begin
          along <= along_next;
          if (div_start) begin
            state <= S_DV;
          end else begin
            progress <= FULL;
            state    <= S_MB;
          end
        end
        S_DV: begin
          if (div_done) begin
            progress <= {1'b0, div_quot};
            state    <= S_MB;
          end
        end
        S_MB: state <= S_MC;
        S_MC: begin
          base  <= base_c;
          state <= S_FN;
        end
        S_FN: begin
          out_valid <= 1'b1;
          if (in_tol && settled) begin
            run_status  <= RUN_OK;
            finished    <= 1'b1;
            succeeded   <= 1'b1;
            left_drive  <= '0;
            right_drive <= '0;
          end else begin
            finished    <= 1'b0;
            succeeded   <= 1'b0;
            left_drive  <= left_c[8:0];
            right_drive <= right_c[8:0];
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SDC_ASSERT(a_fin_no_drive, out_valid && finished |-> left_drive == 9'sd0 && right_drive == 9'sd0, "finished result carries drive")
  `SDC_ASSERT(a_ok_needs_fin, out_valid && succeeded |-> finished, "success without finished")
  `SDC_ASSERT(a_progress_range, out_valid |-> progress <= FULL, "progress above one")
  `SDC_ASSERT_NEXT(a_cordic_seq, cor_done, state == S_IDLE, "cordic done outside start sequence")

endmodule

// ===== verif/drive_checker.sv =====
// checker for the straight drive controller: predicts each update result and compares
module drive_checker
  import sdc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         action,
  input  logic signed [19:0] pose_x,
  input  logic signed [19:0] pose_y,
  input  logic signed [15:0] pose_heading,
  input  logic signed [20:0] time_step,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [8:0]  left_drive,
  input  logic signed [8:0]  right_drive,
  input  logic               finished,
  input  logic               succeeded,
  input  logic [16:0]        progress,
  output int                 pending,
  output int                 errors
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint MAX_DRIVE = 255;
  localparam longint MIN_DRIVE = 40;
  localparam longint DEAD_ZONE = 10;
  localparam int REG_WIDTH [8] = '{20, 16, 15, 20, 20, 19, 32, 15};

  typedef struct {
    logic [8:0]  left;
    logic [8:0]  right;
    logic        fin;
    logic        ok;
    logic [16:0] prog;
  } drive_result_t;

  drive_result_t expected_drive [$];

  longint     regs [8];
  logic [1:0] status;
  longint     org_x, org_y, org_heading, org_cos, org_sin, goal, elapsed, frac;

  initial begin
    errors = 0;
    pending = 0;
  end

  function automatic longint wrap_half_turn(longint a);
    if (a <= -longint'(ANG_PI)) return a + longint'(ANG_TWO_PI);
    if (a > longint'(ANG_PI)) return a - longint'(ANG_TWO_PI);
    return a;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint trunc_down(longint v, int s);
    return v >= 0 ? v >>> s : -((-v) >>> s);
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint wheel(longint v);
    v = clip(v, -MAX_DRIVE, MAX_DRIVE);
    if (v > -DEAD_ZONE && v < DEAD_ZONE) return 0;
    return v;
  endfunction

  function automatic longint steer(longint herr);
    return clip(trunc_down(regs[REG_HEAD_GAIN] * herr, 21),
                -regs[REG_MAX_CORR], regs[REG_MAX_CORR]);
  endfunction

  task automatic heading_vector(input longint ang, output longint c, output longint s);
    longint a, x, y, z, xs, ys;
    bit flip;
    a = wrap_half_turn(ang);
    flip = 0;
    x = longint'(CORDIC_GAIN_Q20);
    y = 0;
    if (a > longint'(ANG_HALF_PI)) begin
      a = a - longint'(ANG_PI);
      flip = 1;
    end else if (a < -longint'(ANG_HALF_PI)) begin
      a = a + longint'(ANG_PI);
      flip = 1;
    end
    z = a * 8;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(ATAN_Q16[i]);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(ATAN_Q16[i]);
      end
    end
    x = clip((x + 32) >>> 6, -16384, 16384);
    y = clip((y + 32) >>> 6, -16384, 16384);
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic predict_update(output drive_result_t r);
    longint l, rt, along, remaining, herr, corr, base, dt;
    bit fin;
    l = 0;
    rt = 0;
    fin = 1;
    dt = longint'(time_step);
    if (status == RUN_BUSY) begin
      if (dt > 0) begin
        elapsed = elapsed + dt;
        if (elapsed > 64'hFFFF_FFFF) elapsed = 64'hFFFF_FFFF;
      end
      if (regs[REG_TIMEOUT] != 0 && elapsed > regs[REG_TIMEOUT]) begin
        status = RUN_FAIL;
      end else begin
        along = ((longint'(pose_x) - org_x) * org_cos +
                 (longint'(pose_y) - org_y) * org_sin) >>> 14;
        remaining = goal - along;
        if (goal != 0) frac = clip((mag(along) * 65536) / mag(goal), 0, 65536);
        else frac = 65536;
        herr = wrap_half_turn(org_heading - longint'(pose_heading));
        if (mag(remaining) <= regs[REG_POS_TOL]) begin
          if (mag(herr) <= regs[REG_HEAD_TOL]) begin
            status = RUN_OK;
          end else begin
            corr = steer(herr);
            l = wheel(-corr);
            rt = wheel(corr);
            fin = 0;
          end
        end else begin
          base = clip(trunc_down(regs[REG_DIST_GAIN] * remaining, 18), -MAX_DRIVE, MAX_DRIVE);
          // minimum drive only outside the slow zone
          if (mag(remaining) > regs[REG_SLOW_ZONE] && base != 0 && mag(base) < MIN_DRIVE)
            base = base < 0 ? -MIN_DRIVE : MIN_DRIVE;
          corr = steer(herr);
          l = wheel(base - corr);
          rt = wheel(base + corr);
          fin = 0;
        end
      end
    end
    r.left = l[8:0];
    r.right = rt[8:0];
    r.fin = fin;
    r.ok = fin && status == RUN_OK;
    r.prog = frac[16:0];
  endtask

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    drive_result_t r;
    if (rst) begin
      for (int i = 0; i < 8; i++) regs[i] = 0;
      regs[REG_POS_TOL] = 20;
      regs[REG_HEAD_TOL] = 400;
      status = RUN_IDLE;
      org_x = 0; org_y = 0; org_heading = 0; org_cos = 0; org_sin = 0;
      goal = 0; elapsed = 0; frac = 0;
      expected_drive.delete();
    end else begin
      if (cfg_write)
        regs[cfg_index] = longint'(cfg_data & ((33'h1 << REG_WIDTH[cfg_index]) - 1));
      if (out_valid && !out_stall) begin
        if (expected_drive.size() == 0) begin
          report("unexpected transaction", 1, 0);
        end else begin
          r = expected_drive.pop_front();
          if (left_drive !== r.left) report("left_drive", left_drive, $signed(r.left));
          if (right_drive !== r.right) report("right_drive", right_drive, $signed(r.right));
          if (finished !== r.fin) report("finished", finished, r.fin);
          if (succeeded !== r.ok) report("succeeded", succeeded, r.ok);
          if (progress !== r.prog) report("progress", progress, r.prog);
        end
      end
      if (in_valid && !in_stall) begin
        case (action)
          ACT_START: begin
            org_x = longint'(pose_x);
            org_y = longint'(pose_y);
            org_heading = longint'(pose_heading);
            heading_vector(org_heading, org_cos, org_sin);
            goal = longint'($signed(regs[REG_TARGET][19:0]));
            elapsed = 0;
            frac = 0;
            status = RUN_BUSY;
          end
          ACT_CANCEL: status = RUN_FAIL;
          ACT_UPDATE: begin
            predict_update(r);
            expected_drive.push_back(r);
          end
          default: ;
        endcase
      end
    end
    pending = expected_drive.size();
  end
endmodule

// ===== verif/testbench.sv =====
// top of the straight drive controller testbench: clock, stimulus and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sdc_pkg::*;

  logic               clk, rst;
  logic               cfg_write;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               in_valid, in_stall;
  logic [1:0]         action;
  logic signed [19:0] pose_x, pose_y;
  logic signed [15:0] pose_heading;
  logic signed [20:0] time_step;
  logic               out_valid, out_stall;
  logic signed [8:0]  left_drive, right_drive;
  logic               finished, succeeded;
  logic [16:0]        progress;
  int                 pending, errors;
  bit                 quiet;

  int  cur_goal;
  int  home_x, home_y, home_h;
  bit  in_run;

  straight_drive_controller uut (.*);
  drive_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("testbench: done, errors");
    $finish;
  end

  // receiver stall bursts
  initial begin
    int burst;
    burst = 0;
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (quiet || rst) begin
        out_stall = 0;
      end else if (burst > 0) begin
        burst--;
        out_stall = 1;
      end else begin
        out_stall = 0;
        if ($urandom_range(0, 5) == 0) burst = $urandom_range(1, 14);
      end
    end
  end

  task automatic send(input logic [1:0] a, input int x, input int y, input int h, input int t);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid = 0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid = 1;
    action = a;
    pose_x = x[19:0];
    pose_y = y[19:0];
    pose_heading = h[15:0];
    time_step = t[20:0];
    do @(posedge clk); while (in_stall);
  endtask

  // drain all results, then cover the start cordic that gives no result
  task automatic settle();
    @(negedge clk);
    in_valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input longint unsigned val);
    @(negedge clk);
    cfg_write = 1;
    cfg_index = idx;
    cfg_data = val[31:0];
  endtask

  task automatic load_regs(input int tgt, input int ptol, input int htol, input int dg,
                           input int hg, input int sz, input longint unsigned tmo,
                           input int mc);
    settle();
    write_reg(REG_TARGET, tgt & 20'hFFFFF);
    write_reg(REG_POS_TOL, ptol);
    write_reg(REG_HEAD_TOL, htol);
    write_reg(REG_DIST_GAIN, dg);
    write_reg(REG_HEAD_GAIN, hg);
    write_reg(REG_SLOW_ZONE, sz);
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_MAX_CORR, mc);
    @(negedge clk);
    cfg_write = 0;
    cur_goal = tgt;
  endtask

  function automatic int rnd_full(int bits);
    return int'($urandom) >>> (32 - bits);
  endfunction

  task automatic begin_run();
    home_h = $urandom_range(0, 9) == 0 ? rnd_full(16) : $urandom_range(0, 51471) - 25735;
    home_x = $urandom_range(0, 400000) - 200000;
    home_y = $urandom_range(0, 400000) - 200000;
    in_run = 1;
    send(ACT_START, home_x, home_y, home_h, rnd_full(21));
  endtask

  // update on the line of the start heading, near or far from the goal
  task automatic track_update();
    real d, ang;
    int  off, herr, dt;
    case ($urandom_range(0, 3))
      0: off = $urandom_range(0, 60) - 30;
      1: off = $urandom_range(0, 4000) - 2000;
      2: off = cur_goal;
      default: off = rnd_full(18);
    endcase
    d = real'(cur_goal - off);
    ang = real'(home_h) / 8192.0;
    herr = $urandom_range(0, 1) ? $urandom_range(0, 1200) - 600 : rnd_full(16);
    case ($urandom_range(0, 9))
      0: dt = -$urandom_range(1, 1000000);
      1: dt = rnd_full(21);
      default: dt = $urandom_range(0, 3000);
    endcase
    send(ACT_UPDATE, home_x + $rtoi(d * $cos(ang)), home_y + $rtoi(d * $sin(ang)),
         home_h - herr, dt);
  endtask

  task automatic run_items(input int n);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (!in_run ? r < 50 : r < 6) begin
        begin_run();
      end else if (r < 9) begin
        in_run = 0;
        send(ACT_CANCEL, rnd_full(20), rnd_full(20), rnd_full(16), rnd_full(21));
      end else if (r < 11) begin
        send(ACT_UNUSED, rnd_full(20), rnd_full(20), rnd_full(16), rnd_full(21));
      end else if (r < 17 || !in_run) begin
        send(ACT_UPDATE, rnd_full(20), rnd_full(20), rnd_full(16), rnd_full(21));
      end else begin
        track_update();
      end
    end
  endtask

  initial begin
    rst = 1;
    quiet = 0;
    in_run = 0;
    cfg_write = 0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 0;
    action = ACT_UPDATE;
    pose_x = '0;
    pose_y = '0;
    pose_heading = '0;
    time_step = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: idle behavior, drive regions, settling, extremes, timeout
    send(ACT_UPDATE, 0, 0, 0, 0);
    send(ACT_CANCEL, 0, 0, 0, 0);
    send(ACT_UPDATE, 0, 0, 0, 0);
    load_regs(10000, 20, 400, 25600, 51200, 500, 100000, 100);
    send(ACT_START, 0, 0, 0, 0);
    send(ACT_UPDATE, 0, 0, 0, 100);
    send(ACT_UPDATE, 9000, 0, 0, 100);
    send(ACT_UPDATE, 9900, 0, 0, -1000000);
    send(ACT_UPDATE, 9995, 0, 8000, 100);
    send(ACT_UPDATE, 9995, 0, 32767, 100);
    send(ACT_UPDATE, 9995, 0, -32768, 100);
    send(ACT_UNUSED, 524287, -524288, 32767, 1048575);
    send(ACT_UPDATE, 10005, 3, 100, 100);
    send(ACT_UPDATE, 10005, 3, 100, 100);
    send(ACT_START, 524287, -524288, 25736, 0);
    send(ACT_UPDATE, -524288, 524287, -25735, 1000000);
    send(ACT_UPDATE, 0, 0, 0, 0);
    send(ACT_START, 100, 100, -25735, 0);
    send(ACT_CANCEL, 100, 100, 0, 0);
    send(ACT_UPDATE, 100, 100, 0, 0);
    // sender holds off until every result is in
    settle();
    load_regs(0, 20, 400, 25600, 51200, 0, 0, 300);
    send(ACT_START, 0, 0, 12868, 0);
    send(ACT_UPDATE, 50, 40, 12868, 5);
    send(ACT_UPDATE, 0, 0, 12868, 5);

    load_regs(20000, 30, 300, 12800, 76800, 2000, 0, 200);
    in_run = 0;
    run_items(90);
    load_regs(524287, 65535, 25736, 1048575, 1048575, 524287, 64'hFFFF_FFFF, 32767);
    in_run = 0;
    run_items(80);
    load_regs(-524288, 0, 0, 0, 0, 0, 1, 0);
    in_run = 0;
    run_items(60);
    load_regs(0, 50, 500, 40000, 90000, 100, 20000, 150);
    in_run = 0;
    run_items(70);
    load_regs(-30000, 40, 200, 20000, 300000, 3000, 5000, 255);
    in_run = 0;
    run_items(100);
    load_regs(int'($urandom_range(0, 80000)) - 40000, $urandom_range(0, 200),
              $urandom_range(0, 2000), $urandom_range(0, 1048575),
              $urandom_range(0, 1048575), $urandom_range(0, 20000),
              $urandom_range(0, 200000), $urandom_range(0, 32767));
    in_run = 0;
    quiet = 1;
    run_items(120);

    @(negedge clk);
    in_valid = 0;
    for (int i = 0; i < 5000 && pending != 0; i++) @(negedge clk);
    repeat (40) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sdc_pkg.sv
rtl/sdc_mul.sv
rtl/sdc_cordic.sv
rtl/sdc_div.sv
rtl/straight_drive_controller.sv
verif/drive_checker.sv
verif/testbench.sv
